[hw/rtl/iee_pkg.sv]
package iee_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int DIV_CNT_W   = $clog2(VALUE_WIDTH + 1);

  typedef logic [VALUE_WIDTH-1:0] value_t;

  // expression characters (ASCII)
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_STAR    = 8'h2A;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OP_SCAN,
    ST_OP_DIV,
    ST_FIN_PUSH,
    ST_FIN_SCAN,
    ST_FIN_DIV,
    ST_EMIT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic push_acc;
    logic reduce_alu;
    logic div_start;
    logic reduce_div;
    logic push_op;
    logic emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_is_op;
    logic in_last;
    logic last_q;
    logic opr_nonempty;
    logic top_low;
    logic new_high;
    logic top_is_div;
    logic div_done;
    logic out_free;
  } status_t;

  function automatic logic is_op_char(input logic [7:0] c);
    return (c == CHAR_PLUS) || (c == CHAR_MINUS) || (c == CHAR_STAR) ||
           (c == CHAR_SLASH) || (c == CHAR_PERCENT);
  endfunction

  function automatic op_e op_of_char(input logic [7:0] c);
    op_e op;
    unique case (c)
      CHAR_MINUS:   op = OP_SUB;
      CHAR_STAR:    op = OP_MUL;
      CHAR_SLASH:   op = OP_DIV;
      CHAR_PERCENT: op = OP_MOD;
      default:      op = OP_ADD;
    endcase
    return op;
  endfunction

  function automatic logic is_low_prec(input op_e op);
    return (op == OP_ADD) || (op == OP_SUB);
  endfunction

endpackage

[hw/rtl/iee_if.sv]
interface iee_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

interface iee_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [iee_pkg::VALUE_WIDTH-1:0] value;
  logic                                 divide_error;

  modport source (output valid, output value, output divide_error, input ready);
  modport sink   (input valid, input value, input divide_error, output ready);
endinterface

[hw/rtl/iee_divider.sv]
module iee_divider (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  iee_pkg::value_t dividend_i,
  input  iee_pkg::value_t divisor_i,
  output logic            done_o,
  output iee_pkg::value_t quotient_o,
  output iee_pkg::value_t remainder_o
);
  import iee_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  value_t               quot_q, quot_d;
  value_t               rem_q, rem_d;
  value_t               dvs_q, dvs_d;

  logic [VALUE_WIDTH:0] shifted;
  logic [VALUE_WIDTH:0] diff;

  // restoring division, one quotient bit per cycle
  assign shifted = {rem_q, quot_q[VALUE_WIDTH-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(VALUE_WIDTH);
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[VALUE_WIDTH]) begin
        rem_d  = diff[VALUE_WIDTH-1:0];
        quot_d = {quot_q[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem_d  = shifted[VALUE_WIDTH-1:0];
        quot_d = {quot_q[VALUE_WIDTH-2:0], 1'b0};
      end
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quot_q;
  assign remainder_o = rem_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

endmodule

[hw/rtl/iee_datapath.sv]
module iee_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  iee_pkg::cmd_t    cmd_i,
  output iee_pkg::status_t status_o,
  input  logic [7:0]       char_character_i,
  input  logic             char_last_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output iee_pkg::value_t  out_value_o,
  output logic             out_error_o
);
  import iee_pkg::*;

  // operand stack: s0 is the top; operator stack: op0 is the top
  value_t      s0_q, s0_d, s1_q, s1_d, s2_q, s2_d;
  logic [1:0]  opnd_cnt_q, opnd_cnt_d;
  op_e         op0_q, op0_d, op1_q, op1_d;
  logic [1:0]  opr_cnt_q, opr_cnt_d;
  value_t      acc_q, acc_d;
  logic        err_q, err_d;
  op_e         new_op_q, new_op_d;
  logic        last_q, last_d;
  logic        out_valid_q, out_valid_d;
  value_t      out_value_q, out_value_d;
  logic        out_err_q, out_err_d;

  logic        in_is_digit;
  logic        in_is_op;
  logic [3:0]  digit;
  logic        push_en;
  logic        reduce_en;
  value_t      red_res;
  value_t      alu_res;
  value_t      div_res;
  value_t      product;
  logic        sa, sb, b_zero;
  value_t      mag_a, mag_b;
  value_t      quot, rem;
  logic        div_done;

  assign in_is_digit = (char_character_i >= CHAR_ZERO) && (char_character_i <= CHAR_NINE);
  assign in_is_op    = is_op_char(char_character_i);
  assign digit       = 4'(char_character_i - CHAR_ZERO);

  assign sa     = s1_q[VALUE_WIDTH-1];
  assign sb     = s0_q[VALUE_WIDTH-1];
  assign b_zero = (s0_q == '0);
  assign mag_a  = sa ? ('0 - s1_q) : s1_q;
  assign mag_b  = sb ? ('0 - s0_q) : s0_q;

  iee_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (mag_a),
    .divisor_i   (mag_b),
    .done_o      (div_done),
    .quotient_o  (quot),
    .remainder_o (rem)
  );

  assign product = s1_q * s0_q;

  always_comb begin
    unique case (op0_q)
      OP_ADD:  alu_res = s1_q + s0_q;
      OP_SUB:  alu_res = s1_q - s0_q;
      default: alu_res = product;
    endcase
  end

  // truncating division, 0 on a zero divisor; the remainder takes the dividend's sign
  always_comb begin
    if (b_zero) begin
      div_res = '0;
    end else if (op0_q == OP_DIV) begin
      div_res = (sa ^ sb) ? ('0 - quot) : quot;
    end else begin
      div_res = sa ? ('0 - rem) : rem;
    end
  end

  assign push_en   = (cmd_i.accept && in_is_op) || cmd_i.push_acc;
  assign reduce_en = cmd_i.reduce_alu || cmd_i.reduce_div;
  assign red_res   = cmd_i.reduce_div ? div_res : alu_res;

  always_comb begin
    s0_d        = s0_q;
    s1_d        = s1_q;
    s2_d        = s2_q;
    opnd_cnt_d  = opnd_cnt_q;
    op0_d       = op0_q;
    op1_d       = op1_q;
    opr_cnt_d   = opr_cnt_q;
    acc_d       = acc_q;
    err_d       = err_q;
    new_op_d    = new_op_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_err_d   = out_err_q;

    if (cmd_i.accept) begin
      last_d = char_last_i;
      if (in_is_digit) begin
        acc_d = (acc_q << 3) + (acc_q << 1) + value_t'(digit);
      end else if (in_is_op) begin
        new_op_d = op_of_char(char_character_i);
      end
    end

    if (push_en) begin
      acc_d = '0;
      if (opnd_cnt_q != 2'd3) begin
        s2_d       = s1_q;
        s1_d       = s0_q;
        s0_d       = acc_q;
        opnd_cnt_d = opnd_cnt_q + 2'd1;
      end
    end

    if (reduce_en) begin
      op0_d     = op1_q;
      opr_cnt_d = opr_cnt_q - 2'd1;
      if (opnd_cnt_q >= 2'd2) begin
        s0_d       = red_res;
        s1_d       = s2_q;
        opnd_cnt_d = opnd_cnt_q - 2'd1;
      end
      if (cmd_i.reduce_div && b_zero) begin
        err_d = 1'b1;
      end
    end

    if (cmd_i.push_op && (opr_cnt_q < 2'd2)) begin
      op1_d     = op0_q;
      op0_d     = new_op_q;
      opr_cnt_d = opr_cnt_q + 2'd1;
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_value_d = (opnd_cnt_q != 2'd0) ? s0_q : '0;
      out_err_d   = err_q;
      opnd_cnt_d  = '0;
      opr_cnt_d   = '0;
      acc_d       = '0;
      err_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opnd_cnt_q  <= '0;
      opr_cnt_q   <= '0;
      acc_q       <= '0;
      err_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      opnd_cnt_q  <= opnd_cnt_d;
      opr_cnt_q   <= opr_cnt_d;
      acc_q       <= acc_d;
      err_q       <= err_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q        <= s0_d;
    s1_q        <= s1_d;
    s2_q        <= s2_d;
    op0_q       <= op0_d;
    op1_q       <= op1_d;
    new_op_q    <= new_op_d;
    out_value_q <= out_value_d;
    out_err_q   <= out_err_d;
  end

  assign status_o.in_is_op     = in_is_op;
  assign status_o.in_last      = char_last_i;
  assign status_o.last_q       = last_q;
  assign status_o.opr_nonempty = (opr_cnt_q != 2'd0);
  assign status_o.top_low      = is_low_prec(op0_q);
  assign status_o.new_high     = !is_low_prec(new_op_q);
  assign status_o.top_is_div   = (op0_q == OP_DIV) || (op0_q == OP_MOD);
  assign status_o.div_done     = div_done;
  assign status_o.out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_error_o = out_err_q;

  a_opr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    opr_cnt_q != 2'd3)
    else $error("operator stack overflow");

  a_reduce_has_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reduce_en |-> (opr_cnt_q != 2'd0) && (opnd_cnt_q >= 2'd2))
    else $error("reduction without enough operands or operators");

  a_div_wb_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.reduce_div |-> div_done)
    else $error("division written back before the divider finished");

  a_emit_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while held");

endmodule

[hw/rtl/iee_ctrl.sv]
module iee_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  iee_pkg::status_t status_i,
  output iee_pkg::cmd_t    cmd_o
);
  import iee_pkg::*;

  state_e state_q, state_d;
  logic   op_reduce;
  logic   fin_reduce;

  // an incoming + or - reduces everything; * / % stop at a pending + or -
  assign op_reduce  = status_i.opr_nonempty && !(status_i.top_low && status_i.new_high);
  assign fin_reduce = status_i.opr_nonempty;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (status_i.in_is_op) begin
            state_d = ST_OP_SCAN;
          end else if (status_i.in_last) begin
            state_d = ST_FIN_PUSH;
          end
        end
      end
      ST_OP_SCAN: begin
        if (op_reduce) begin
          if (status_i.top_is_div) begin
            state_d = ST_OP_DIV;
          end
        end else begin
          state_d = status_i.last_q ? ST_FIN_PUSH : ST_IDLE;
        end
      end
      ST_OP_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_OP_SCAN;
        end
      end
      ST_FIN_PUSH: state_d = ST_FIN_SCAN;
      ST_FIN_SCAN: begin
        if (fin_reduce) begin
          if (status_i.top_is_div) begin
            state_d = ST_FIN_DIV;
          end
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_FIN_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_FIN_SCAN;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_OP_SCAN: begin
        if (op_reduce) begin
          cmd_o.div_start  = status_i.top_is_div;
          cmd_o.reduce_alu = !status_i.top_is_div;
        end else begin
          cmd_o.push_op = 1'b1;
        end
      end
      ST_OP_DIV, ST_FIN_DIV: begin
        cmd_o.reduce_div = status_i.div_done;
      end
      ST_FIN_PUSH: cmd_o.push_acc = 1'b1;
      ST_FIN_SCAN: begin
        if (fin_reduce) begin
          cmd_o.div_start  = status_i.top_is_div;
          cmd_o.reduce_alu = !status_i.top_is_div;
        end
      end
      ST_EMIT: cmd_o.emit = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/infix_expression_evaluator_core.sv]
// Infix expression evaluator.
// char_i takes one expression character per transaction, with last marking
// the final one. Digits accumulate into a 32-bit number; + - * / % are
// operators (* / % bind tighter); all other characters are ignored.
// result_o carries one transaction per expression: the signed value and a
// flag that is set if any division or modulo by zero occurred.
// A digit or ignored character is taken in the idle state. An operator
// is taken, then reduces (+ - * in the ALU; / or % start the 32-step
// restoring divider and wait for it) and is then pushed; at most two
// reductions happen. After a last character the operand is pushed, what
// is left is reduced and the result goes into the output register.
// Division truncates toward zero; the most negative value divided by -1
// wraps to itself; division or modulo by zero gives 0.
// The result is held in an output register, so the next expression is
// taken while a result waits; if a second result is ready before the first
// is taken, the block stops accepting characters until result_o drains.
// Reset clears the FSM, counters and flags and drops result_o.valid.
module infix_expression_evaluator_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  iee_char_if.sink     char_i,
  iee_result_if.source result_o
);
  import iee_pkg::*;

  cmd_t    cmd;
  status_t status;
  value_t  out_value;

  iee_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (char_i.valid),
    .in_ready_o (char_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  iee_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .char_character_i (char_i.character),
    .char_last_i      (char_i.last),
    .out_ready_i      (result_o.ready),
    .out_valid_o      (result_o.valid),
    .out_value_o      (out_value),
    .out_error_o      (result_o.divide_error)
  );

  assign result_o.value = $signed(out_value);

endmodule
